// ----- hdl/aarm_pkg.sv -----
`default_nettype none
package aarm_pkg;

  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int WORK_FRAC         = 30;
  localparam int CORDIC_STEPS      = 24;
  localparam int SQRT_STEPS        = 32;
  localparam int DIV_STEPS         = 31;
  localparam int FIELD_W           = 16;

  typedef logic signed [33:0] wq_t;
  typedef logic signed [FIELD_W-1:0] fld_t;

  localparam wq_t CORDIC_GAIN_INV = 34'sd652032875;
  localparam wq_t ONE_Q30         = 34'sd1073741824;

  typedef struct packed {
    logic [31:0] z;
    logic [1:0]  quad;
    logic [2:0]  sgn;
    logic [2:0][15:0] mag;
    logic [31:0] n2;
    logic        zero;
  } stg_a_t;

  typedef struct packed {
    wq_t               x;
    wq_t               y;
    logic signed [32:0] z;
    logic [1:0]        quad;
  } cordic_t;

  typedef struct packed {
    wq_t c;
    wq_t s;
  } cs_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] res;
    logic [31:0] src;
    logic [2:0][15:0] mag;
    logic [2:0]  sgn;
    logic        zero;
  } sqrt_t;

  typedef struct packed {
    logic [31:0]      root;
    logic [2:0][31:0] rem;
    logic [30:0]      low;
    logic [2:0][30:0] q;
    logic [2:0]       sgn;
    logic             zero;
  } div_t;

  typedef struct packed {
    wq_t  ux;
    wq_t  uy;
    wq_t  uz;
    logic zero;
  } unit_t;

  function automatic logic signed [32:0] atan_turn(input logic [4:0] idx);
    logic signed [32:0] v;
    case (idx)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      5'd20: v = 33'sd652;
      5'd21: v = 33'sd326;
      5'd22: v = 33'sd163;
      5'd23: v = 33'sd81;
      5'd24: v = 33'sd41;
      5'd25: v = 33'sd20;
      5'd26: v = 33'sd10;
      5'd27: v = 33'sd5;
      5'd28: v = 33'sd3;
      5'd29: v = 33'sd1;
      5'd30: v = 33'sd1;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

  // Q3.30 product, rounded half up
  function automatic wq_t mulq(input wq_t a, input wq_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return p[63:30];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/aarm_in_if.sv -----
`default_nettype none
interface aarm_in_if import aarm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] angle;
  fld_t        axis_x;
  fld_t        axis_y;
  fld_t        axis_z;

  modport source (output valid, angle, axis_x, axis_y, axis_z, input ready);
  modport sink   (input valid, angle, axis_x, axis_y, axis_z, output ready);
endinterface
`default_nettype wire

// ----- hdl/aarm_out_if.sv -----
`default_nettype none
interface aarm_out_if import aarm_pkg::*; ();
  logic valid;
  logic ready;
  fld_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic zero_axis;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, zero_axis,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, zero_axis,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/axis_angle_rotation_matrix_top.sv -----
// Axis-angle to 3x3 rotation matrix.
// in_ch carries one item: angle (binary angle, 2^ANGLE_WIDTH per turn) and
// a three-component axis at any scale. out_ch returns one item per input:
// the nine matrix entries r00..r22 in signed Q1.OUT_FRAC_BITS and zero_axis,
// which flags an all-zero axis (identity emitted).
// An item passes 69 register stages: one input stage, 32 square-root stages
// and 31 divider stages normalize the axis (a 24-stage CORDIC for sine and
// cosine runs alongside), one sign stage and four multiply, sum and round
// stages. The square root and the divider retire one result bit per stage,
// which sets the depth.
// Throughput is one item per cycle while out_ch.ready stays high.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ch.ready drops; nothing is lost or repeated. Empty stages advance
// whenever the output register is empty.
// Reset clears all stage valid bits, after which the block is ready.
`default_nettype none
module axis_angle_rotation_matrix_top
  import aarm_pkg::*;
#(
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  aarm_in_if.sink     in_ch,
  aarm_out_if.source  out_ch
);

  localparam int CS_DLY = SQRT_STEPS + DIV_STEPS - CORDIC_STEPS;
  localparam int TOTAL  = 1 + SQRT_STEPS + DIV_STEPS + 1 + 4;
  localparam int SH     = WORK_FRAC - OUT_FRAC_BITS;
  localparam logic [34:0] RND = 35'((64'd1 << SH) >> 1);
  localparam logic signed [34:0] ONE_OUT = 35'sd1 <<< OUT_FRAC_BITS;
  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_WIDTH) - 64'd1);

  function automatic logic [15:0] to_out(input wq_t v);
    logic signed [34:0] t;
    logic signed [34:0] r;
    t = 35'(v) + $signed(RND);
    r = t >>> SH;
    if (r > ONE_OUT) r = ONE_OUT;
    if (r < -ONE_OUT) r = -ONE_OUT;
    return r[15:0];
  endfunction

  logic ce;
  logic [TOTAL-1:0] vld_r;

  assign ce          = !vld_r[TOTAL-1] || out_ch.ready;
  assign in_ch.ready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[TOTAL-2:0], in_ch.valid};
    end
  end

  // input stage: magnitudes, squared length, phase folding
  stg_a_t a_r, a_nxt;
  logic [31:0] ph, ph_off;
  logic [33:0] sq_sum;
  logic [2:0][15:0] mag_c;
  logic [2:0] sgn_c;

  always_comb begin
    sgn_c    = {in_ch.axis_z[15], in_ch.axis_y[15], in_ch.axis_x[15]};
    mag_c[0] = sgn_c[0] ? 16'(-in_ch.axis_x) : in_ch.axis_x;
    mag_c[1] = sgn_c[1] ? 16'(-in_ch.axis_y) : in_ch.axis_y;
    mag_c[2] = sgn_c[2] ? 16'(-in_ch.axis_z) : in_ch.axis_z;
    sq_sum   = 34'(mag_c[0]) * 34'(mag_c[0]) + 34'(mag_c[1]) * 34'(mag_c[1])
             + 34'(mag_c[2]) * 34'(mag_c[2]);
    ph       = ({16'd0, in_ch.angle} & AMASK) << (32 - ANGLE_WIDTH);
    ph_off   = ph + 32'h2000_0000;
    a_nxt.quad = ph_off[31:30];
    a_nxt.z    = ph - {ph_off[31:30], 30'd0};
    a_nxt.sgn  = sgn_c;
    a_nxt.mag  = mag_c;
    a_nxt.n2   = sq_sum[31:0];
    a_nxt.zero = (in_ch.axis_x == '0) && (in_ch.axis_y == '0) && (in_ch.axis_z == '0);
  end

  always_ff @(posedge clk) begin
    if (ce) a_r <= a_nxt;
  end

  // CORDIC, one micro-rotation per stage
  cordic_t cr_in  [CORDIC_STEPS];
  cordic_t cr_nxt [CORDIC_STEPS];
  cordic_t cr_r   [CORDIC_STEPS];

  always_comb begin
    cr_in[0].x    = CORDIC_GAIN_INV;
    cr_in[0].y    = '0;
    cr_in[0].z    = 33'($signed(a_r.z));
    cr_in[0].quad = a_r.quad;
    for (int k = 1; k < CORDIC_STEPS; k++) cr_in[k] = cr_r[k-1];
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      cr_nxt[k].quad = cr_in[k].quad;
      if (!cr_in[k].z[32]) begin
        cr_nxt[k].x = cr_in[k].x - (cr_in[k].y >>> k);
        cr_nxt[k].y = cr_in[k].y + (cr_in[k].x >>> k);
        cr_nxt[k].z = cr_in[k].z - atan_turn(5'(k));
      end else begin
        cr_nxt[k].x = cr_in[k].x + (cr_in[k].y >>> k);
        cr_nxt[k].y = cr_in[k].y - (cr_in[k].x >>> k);
        cr_nxt[k].z = cr_in[k].z + atan_turn(5'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < CORDIC_STEPS; k++) cr_r[k] <= cr_nxt[k];
    end
  end

  // quadrant unfold, then delay to meet the normalized axis
  cs_t cs_nxt;
  cs_t dl_r [CS_DLY+1];

  always_comb begin
    case (cr_r[CORDIC_STEPS-1].quad)
      2'd0: begin
        cs_nxt.c = cr_r[CORDIC_STEPS-1].x;
        cs_nxt.s = cr_r[CORDIC_STEPS-1].y;
      end
      2'd1: begin
        cs_nxt.c = -cr_r[CORDIC_STEPS-1].y;
        cs_nxt.s = cr_r[CORDIC_STEPS-1].x;
      end
      2'd2: begin
        cs_nxt.c = -cr_r[CORDIC_STEPS-1].x;
        cs_nxt.s = -cr_r[CORDIC_STEPS-1].y;
      end
      default: begin
        cs_nxt.c = cr_r[CORDIC_STEPS-1].y;
        cs_nxt.s = -cr_r[CORDIC_STEPS-1].x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dl_r[0] <= cs_nxt;
      for (int k = 1; k <= CS_DLY; k++) dl_r[k] <= dl_r[k-1];
    end
  end

  // square root of n2 * 2^32, one result bit per stage
  sqrt_t sq_in  [SQRT_STEPS];
  sqrt_t sq_nxt [SQRT_STEPS];
  sqrt_t sq_r   [SQRT_STEPS];
  logic [34:0] sq_cur  [SQRT_STEPS];
  logic [34:0] sq_trial[SQRT_STEPS];

  always_comb begin
    sq_in[0].rem  = '0;
    sq_in[0].res  = '0;
    sq_in[0].src  = a_r.n2;
    sq_in[0].mag  = a_r.mag;
    sq_in[0].sgn  = a_r.sgn;
    sq_in[0].zero = a_r.zero;
    for (int k = 1; k < SQRT_STEPS; k++) sq_in[k] = sq_r[k-1];
    for (int k = 0; k < SQRT_STEPS; k++) begin
      sq_nxt[k]     = sq_in[k];
      sq_cur[k]     = {sq_in[k].rem[32:0], sq_in[k].src[31:30]};
      sq_trial[k]   = {1'b0, sq_in[k].res, 2'b01};
      sq_nxt[k].src = {sq_in[k].src[29:0], 2'b00};
      if (sq_cur[k] >= sq_trial[k]) begin
        sq_nxt[k].rem = sq_cur[k] - sq_trial[k];
        sq_nxt[k].res = {sq_in[k].res[30:0], 1'b1};
      end else begin
        sq_nxt[k].rem = sq_cur[k];
        sq_nxt[k].res = {sq_in[k].res[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < SQRT_STEPS; k++) sq_r[k] <= sq_nxt[k];
    end
  end

  // three restoring dividers: round(mag * 2^46 / root), one quotient bit per stage
  div_t dv_in  [DIV_STEPS];
  div_t dv_nxt [DIV_STEPS];
  div_t dv_r   [DIV_STEPS];
  logic [32:0] dv_cur [DIV_STEPS][3];

  always_comb begin
    dv_in[0].root = sq_r[SQRT_STEPS-1].res;
    dv_in[0].low  = sq_r[SQRT_STEPS-1].res[31:1];
    dv_in[0].q    = '0;
    dv_in[0].sgn  = sq_r[SQRT_STEPS-1].sgn;
    dv_in[0].zero = sq_r[SQRT_STEPS-1].zero;
    for (int l = 0; l < 3; l++) dv_in[0].rem[l] = {1'b0, sq_r[SQRT_STEPS-1].mag[l], 15'd0};
    for (int k = 1; k < DIV_STEPS; k++) dv_in[k] = dv_r[k-1];
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_nxt[k]     = dv_in[k];
      dv_nxt[k].low = {dv_in[k].low[29:0], 1'b0};
      for (int l = 0; l < 3; l++) begin
        dv_cur[k][l] = {dv_in[k].rem[l], dv_in[k].low[30]};
        if (dv_cur[k][l] >= {1'b0, dv_in[k].root}) begin
          dv_nxt[k].rem[l] = 32'(dv_cur[k][l] - {1'b0, dv_in[k].root});
          dv_nxt[k].q[l]   = {dv_in[k].q[l][29:0], 1'b1};
        end else begin
          dv_nxt[k].rem[l] = dv_cur[k][l][31:0];
          dv_nxt[k].q[l]   = {dv_in[k].q[l][29:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < DIV_STEPS; k++) dv_r[k] <= dv_nxt[k];
    end
  end

  // apply signs
  unit_t u_r, u_nxt;
  wq_t   uq [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      uq[l] = wq_t'({3'b000, dv_r[DIV_STEPS-1].q[l]});
      if (dv_r[DIV_STEPS-1].sgn[l]) uq[l] = -uq[l];
    end
    u_nxt.ux   = uq[0];
    u_nxt.uy   = uq[1];
    u_nxt.uz   = uq[2];
    u_nxt.zero = dv_r[DIV_STEPS-1].zero;
  end

  always_ff @(posedge clk) begin
    if (ce) u_r <= u_nxt;
  end

  // first products
  wq_t m1_c_r, m1_t_r;
  wq_t m1_sxx_r, m1_syy_r, m1_szz_r, m1_pxy_r, m1_pxz_r, m1_pyz_r;
  wq_t m1_sx_r, m1_sy_r, m1_sz_r;
  logic m1_zero_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      m1_c_r    <= dl_r[CS_DLY].c;
      m1_t_r    <= ONE_Q30 - dl_r[CS_DLY].c;
      m1_sxx_r  <= mulq(u_r.ux, u_r.ux);
      m1_syy_r  <= mulq(u_r.uy, u_r.uy);
      m1_szz_r  <= mulq(u_r.uz, u_r.uz);
      m1_pxy_r  <= mulq(u_r.ux, u_r.uy);
      m1_pxz_r  <= mulq(u_r.ux, u_r.uz);
      m1_pyz_r  <= mulq(u_r.uy, u_r.uz);
      m1_sx_r   <= mulq(dl_r[CS_DLY].s, u_r.ux);
      m1_sy_r   <= mulq(dl_r[CS_DLY].s, u_r.uy);
      m1_sz_r   <= mulq(dl_r[CS_DLY].s, u_r.uz);
      m1_zero_r <= u_r.zero;
    end
  end

  // second products
  wq_t m2_xyt_r, m2_xzt_r, m2_yzt_r, m2_cdx_r, m2_cdy_r, m2_cdz_r;
  wq_t m2_sxx_r, m2_syy_r, m2_szz_r, m2_sx_r, m2_sy_r, m2_sz_r;
  logic m2_zero_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      m2_xyt_r  <= mulq(m1_pxy_r, m1_t_r);
      m2_xzt_r  <= mulq(m1_pxz_r, m1_t_r);
      m2_yzt_r  <= mulq(m1_pyz_r, m1_t_r);
      m2_cdx_r  <= mulq(m1_c_r, ONE_Q30 - m1_sxx_r);
      m2_cdy_r  <= mulq(m1_c_r, ONE_Q30 - m1_syy_r);
      m2_cdz_r  <= mulq(m1_c_r, ONE_Q30 - m1_szz_r);
      m2_sxx_r  <= m1_sxx_r;
      m2_syy_r  <= m1_syy_r;
      m2_szz_r  <= m1_szz_r;
      m2_sx_r   <= m1_sx_r;
      m2_sy_r   <= m1_sy_r;
      m2_sz_r   <= m1_sz_r;
      m2_zero_r <= m1_zero_r;
    end
  end

  // matrix terms in Q3.30
  wq_t  m3_r [9];
  logic m3_zero_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      m3_r[0]   <= m2_sxx_r + m2_cdx_r;
      m3_r[1]   <= m2_xyt_r - m2_sz_r;
      m3_r[2]   <= m2_xzt_r + m2_sy_r;
      m3_r[3]   <= m2_xyt_r + m2_sz_r;
      m3_r[4]   <= m2_syy_r + m2_cdy_r;
      m3_r[5]   <= m2_yzt_r - m2_sx_r;
      m3_r[6]   <= m2_xzt_r - m2_sy_r;
      m3_r[7]   <= m2_yzt_r + m2_sx_r;
      m3_r[8]   <= m2_szz_r + m2_cdz_r;
      m3_zero_r <= m2_zero_r;
    end
  end

  // round, clamp, substitute identity for a zero axis
  logic [15:0] mat_r [9];
  logic        zero_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int e = 0; e < 9; e++) begin
        if (m3_zero_r) begin
          mat_r[e] <= (e == 0 || e == 4 || e == 8) ? 16'(ONE_OUT) : 16'd0;
        end else begin
          mat_r[e] <= to_out(m3_r[e]);
        end
      end
      zero_r <= m3_zero_r;
    end
  end

  assign out_ch.valid     = vld_r[TOTAL-1];
  assign out_ch.r00       = mat_r[0];
  assign out_ch.r01       = mat_r[1];
  assign out_ch.r02       = mat_r[2];
  assign out_ch.r10       = mat_r[3];
  assign out_ch.r11       = mat_r[4];
  assign out_ch.r12       = mat_r[5];
  assign out_ch.r20       = mat_r[6];
  assign out_ch.r21       = mat_r[7];
  assign out_ch.r22       = mat_r[8];
  assign out_ch.zero_axis = zero_r;

endmodule
`default_nettype wire

// ----- dv/aarm_matrix_checker.sv -----
module aarm_matrix_checker
  import aarm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  aarm_in_if.sink    in_mon,
  aarm_out_if.sink   out_mon,
  output int         fail_count,
  output int         matrix_count,
  output int         zero_axis_count
);

  typedef struct {
    logic signed [15:0] m [9];
    logic               zero_axis;
  } matrix_t;

  matrix_t expected_matrices[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shr(a * b, WORK_FRAC);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // 64-bit shift of mag << 46 overflows only past 2^18, mag fits in 16 bits
  function automatic longint unit_part(longint a, longint unsigned root);
    longint unsigned mag, q;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    q = ((mag << 46) + (root >> 1)) / root;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    longint one, r;
    one = 64'sd1 <<< OUT_FRAC_BITS_DEF;
    r = round_shr(v, WORK_FRAC - OUT_FRAC_BITS_DEF);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  function automatic longint atan_step(int i);
    longint tbl [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  function automatic matrix_t rotation_matrix(logic [15:0] angle, logic signed [15:0] ax_in,
                                              logic signed [15:0] ay_in,
                                              logic signed [15:0] az_in);
    matrix_t r;
    longint ax, ay, az, ux, uy, uz, x, y, z, dx, dy, c, s, t, one;
    longint sxx, syy, szz, xyt, xzt, yzt, sx, sy, sz;
    longint unsigned n2, root;
    logic [31:0] p, zr;
    logic [1:0] quad;
    ax = ax_in; ay = ay_in; az = az_in;
    one = 64'sd1 <<< WORK_FRAC;
    if (ax == 0 && ay == 0 && az == 0) begin
      foreach (r.m[i]) r.m[i] = 0;
      r.m[0] = 16'sd1 <<< OUT_FRAC_BITS_DEF;
      r.m[4] = r.m[0];
      r.m[8] = r.m[0];
      r.zero_axis = 1'b1;
      return r;
    end
    n2 = ax * ax + ay * ay + az * az;
    root = int_sqrt(n2 << 32);
    ux = unit_part(ax, root);
    uy = unit_part(ay, root);
    uz = unit_part(az, root);
    p = {angle, 16'd0};
    quad = 2'((p + 32'h2000_0000) >> 30);
    zr = p - {quad, 30'd0};
    z = longint'(signed'(zr));
    x = 652032875;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    t = one - c;
    sxx = qmul(ux, ux); syy = qmul(uy, uy); szz = qmul(uz, uz);
    xyt = qmul(qmul(ux, uy), t);
    xzt = qmul(qmul(ux, uz), t);
    yzt = qmul(qmul(uy, uz), t);
    sx = qmul(s, ux); sy = qmul(s, uy); sz = qmul(s, uz);
    r.m[0] = to_q14(sxx + qmul(c, one - sxx));
    r.m[1] = to_q14(xyt - sz);
    r.m[2] = to_q14(xzt + sy);
    r.m[3] = to_q14(xyt + sz);
    r.m[4] = to_q14(syy + qmul(c, one - syy));
    r.m[5] = to_q14(yzt - sx);
    r.m[6] = to_q14(xzt - sy);
    r.m[7] = to_q14(yzt + sx);
    r.m[8] = to_q14(szz + qmul(c, one - szz));
    r.zero_axis = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on matrix %0d: %s got %0d want %0d",
             $realtime, matrix_count, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    matrix_count = 0;
    zero_axis_count = 0;
  end

  always @(posedge clk) begin
    matrix_t want;
    logic signed [15:0] got [9];
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        expected_matrices.push_back(rotation_matrix(in_mon.angle, in_mon.axis_x,
                                                    in_mon.axis_y, in_mon.axis_z));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.r00, out_mon.r01, out_mon.r02, out_mon.r10, out_mon.r11,
                out_mon.r12, out_mon.r20, out_mon.r21, out_mon.r22};
        if (expected_matrices.size() == 0) begin
          $display("[%0t] matrix with no input waiting", $realtime);
          fail_count++;
        end else begin
          want = expected_matrices.pop_front();
          foreach (got[i])
            if (got[i] !== want.m[i])
              report_mismatch($sformatf("r%0d%0d", i / 3, i % 3), got[i], want.m[i]);
          if (out_mon.zero_axis !== want.zero_axis)
            report_mismatch("zero_axis", out_mon.zero_axis, want.zero_axis);
          if (want.zero_axis) zero_axis_count++;
        end
        matrix_count++;
      end
    end
  end

endmodule

// ----- dv/axis_angle_rotation_matrix_top_tb.sv -----
module axis_angle_rotation_matrix_top_tb;
  import aarm_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT   = 5000;

  logic clk;
  logic rst_n;
  int   fail_count, matrix_count, zero_axis_count;
  int   sent_count;
  int   idle_cycles;
  int   stall_mode;
  bit   timed_out;

  aarm_in_if  in_ch ();
  aarm_out_if out_ch ();

  axis_angle_rotation_matrix_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  aarm_matrix_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch.sink),
    .out_mon         (out_ch.sink),
    .fail_count      (fail_count),
    .matrix_count    (matrix_count),
    .zero_axis_count (zero_axis_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: count cycles without any accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls: switch pattern now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 1) != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_item(logic [15:0] angle, logic [15:0] ax, logic [15:0] ay,
                           logic [15:0] az);
    in_ch.valid  <= 1'b1;
    in_ch.angle  <= angle;
    in_ch.axis_x <= ax;
    in_ch.axis_y <= ay;
    in_ch.axis_z <= az;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic pause_sender(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [15:0] random_axis_part();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    timed_out = 1'b0;
    idle_cycles = 0;
    sent_count = 0;
    stall_mode = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.angle = '0;
    in_ch.axis_x = '0;
    in_ch.axis_y = '0;
    in_ch.axis_z = '0;
    out_ch.ready = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero axis, unit axes, extremes, quadrant boundaries
    send_item(16'h1234, 16'h0000, 16'h0000, 16'h0000);
    send_item(16'hffff, 16'h0000, 16'h0000, 16'h0000);
    send_item(16'h0000, 16'h0001, 16'h0000, 16'h0000);
    send_item(16'h4000, 16'h0000, 16'h0001, 16'h0000);
    send_item(16'h8000, 16'h0000, 16'h0000, 16'h0001);
    send_item(16'hc000, 16'hffff, 16'h0000, 16'h0000);
    send_item(16'h2000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_item(16'h6000, 16'h8000, 16'h8000, 16'h8000);
    send_item(16'ha000, 16'h8000, 16'h7fff, 16'h0001);
    send_item(16'he000, 16'h7fff, 16'h8000, 16'hffff);
    send_item(16'hffff, 16'h0003, 16'hfffc, 16'h0005);
    send_item(16'h0001, 16'h5555, 16'haaaa, 16'h1111);
    send_item(16'h1fff, 16'h0000, 16'h8000, 16'h0000);
    send_item(16'h5fff, 16'h0000, 16'h0000, 16'h7fff);
    send_item(16'h9fff, 16'h0001, 16'h0001, 16'h0001);
    send_item(16'hdfff, 16'hffff, 16'hffff, 16'hffff);
    send_item(16'h8001, 16'h0100, 16'h0000, 16'hff00);

    // random bursts, most of them followed by a gap
    while (sent_count < RANDOM_ITEMS + 17) begin
      burst = $urandom_range(1, 20);
      repeat (burst)
        send_item(16'($urandom), random_axis_part(), random_axis_part(),
                  random_axis_part());
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
    in_ch.valid <= 1'b0;

    while (matrix_count < sent_count) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d axis-angle items sent, %0d matrices checked (%0d zero axis)",
             sent_count, matrix_count, zero_axis_count);
    if (fail_count == 0 && checker_i.expected_matrices.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
